// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define DHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DHK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/dhk_pkg.sv =====
// Package: sizes, beat types, status codes and control structs of the slot table.
package dhk_pkg;

    localparam int unsigned SLOTS     = 64;
    localparam int unsigned KEY_CHARS = 32;
    localparam int unsigned HASH_MULT = 1482907;

    localparam int unsigned SLOT_W  = $clog2(SLOTS);
    localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
    localparam int unsigned LEN_W   = $clog2(KEY_CHARS + 1);
    localparam int unsigned IDX_W   = $clog2(KEY_CHARS);
    localparam int unsigned CADDR_W = $clog2(SLOTS * KEY_CHARS);

    localparam logic [SLOT_W-1:0] HASH_MULT_RED = SLOT_W'(HASH_MULT % SLOTS);

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_CLAIMED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] key_char;
        logic       key_last;
    } key_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        status_t           status;
        logic [CNT_W-1:0]  slots_used;
    } result_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_LEN,
        S_CMP,
        S_COPY,
        S_CLAIM
    } ctrl_state_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_idx;
        logic             clear;
    } kacc_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]  key_len;
        logic              overflow;
        logic [SLOT_W-1:0] hash;
        logic [SLOT_W-1:0] step;
        logic [7:0]        rd_data;
    } kacc_stat_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  pos;
        logic               claim;
        logic [LEN_W-1:0]   claim_len;
        logic               chr_wr_en;
        logic [CADDR_W-1:0] chr_wr_addr;
        logic [7:0]         chr_wr_data;
        logic [CADDR_W-1:0] chr_rd_addr;
    } slot_cmd_t;

    typedef struct packed {
        logic              valid_at_pos;
        logic [LEN_W-1:0]  len_rd;
        logic [7:0]        chr_rd;
        logic [CNT_W-1:0]  count;
    } slot_stat_t;

    function automatic logic [CADDR_W-1:0] char_addr(input logic [SLOT_W-1:0] pos,
                                                     input logic [IDX_W-1:0]  idx);
        return CADDR_W'(32'(pos) * 32'(KEY_CHARS) + 32'(idx));
    endfunction

endpackage

// ===== sv/dhk_key_acc.sv =====
// Key accumulator: key byte buffer, length, overflow flag, primary hash and probe step.
module dhk_key_acc (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_acc,
    input  dhk_pkg::key_beat_t beat,
    input  dhk_pkg::kacc_cmd_t cmd,
    output dhk_pkg::kacc_stat_t stat
);
    import dhk_pkg::*;

    logic [7:0]        kbuf_mem [KEY_CHARS];
    logic [7:0]        rd_data_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [SLOT_W-1:0] hash_reg, hash_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic              buf_wr;
    logic [SLOT_W-1:0] hash_mix;

    assign buf_wr   = beat_acc && (len_reg < LEN_W'(KEY_CHARS));
    assign hash_mix = SLOT_W'(hash_reg * HASH_MULT_RED + SLOT_W'(beat.key_char));

    always_comb begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        hash_next = hash_reg;
        step_next = step_reg;
        if (cmd.clear) begin
            len_next  = '0;
            ovf_next  = 1'b0;
            hash_next = '0;
            step_next = SLOT_W'(1);
        end else if (beat_acc) begin
            if (buf_wr) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
            hash_next = hash_mix;
            step_next = step_reg + SLOT_W'({hash_mix, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            hash_reg <= '0;
            step_reg <= SLOT_W'(1);
        end else begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            hash_reg <= hash_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_wr) begin
            kbuf_mem[len_reg[IDX_W-1:0]] <= beat.key_char;
        end
        rd_data_reg <= kbuf_mem[cmd.rd_idx];
    end

    assign stat.key_len  = len_reg;
    assign stat.overflow = ovf_reg;
    assign stat.hash     = hash_reg;
    assign stat.step     = step_reg;
    assign stat.rd_data  = rd_data_reg;

endmodule

// ===== sv/dhk_slot_store.sv =====
// Slot store: stored key bytes and lengths, claimed marks and the claimed-slot count.
module dhk_slot_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  dhk_pkg::slot_cmd_t cmd,
    output dhk_pkg::slot_stat_t stat
);
    import dhk_pkg::*;

    logic [7:0]       chr_mem [SLOTS * KEY_CHARS];
    logic [LEN_W-1:0] len_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       chr_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else if (cmd.claim) begin
            valid_reg[cmd.pos] <= 1'b1;
            count_reg          <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.claim) begin
            len_mem[cmd.pos] <= cmd.claim_len;
        end
        len_rd_reg <= len_mem[cmd.pos];
    end

    always_ff @(posedge aclk) begin
        if (cmd.chr_wr_en) begin
            chr_mem[cmd.chr_wr_addr] <= cmd.chr_wr_data;
        end
        chr_rd_reg <= chr_mem[cmd.chr_rd_addr];
    end

    assign stat.valid_at_pos = valid_reg[cmd.pos];
    assign stat.len_rd       = len_rd_reg;
    assign stat.chr_rd       = chr_rd_reg;
    assign stat.count        = count_reg;

endmodule

// ===== sv/dhk_ctrl.sv =====
// Probe sequencer: double-hash probing, key compare, slot claim and result register.
module dhk_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  key_last,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dhk_pkg::result_beat_t m_data,
    input  dhk_pkg::kacc_stat_t   kstat,
    output dhk_pkg::kacc_cmd_t    kcmd,
    input  dhk_pkg::slot_stat_t   sstat,
    output dhk_pkg::slot_cmd_t    scmd
);
    import dhk_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] probes_reg, probes_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              copy_wr_reg, copy_wr_next;
    logic [IDX_W-1:0]  copy_idx_reg, copy_idx_next;
    logic              m_valid_reg, m_valid_next;
    result_beat_t      m_data_reg, m_data_next;
    logic              out_free;
    logic              last_byte;
    logic [IDX_W-1:0]  rd_idx;
    logic              key_clear;
    logic              slot_claim;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_byte = (LEN_W'(idx_reg) == kstat.key_len - LEN_W'(1));

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        probes_next   = probes_reg;
        idx_next      = idx_reg;
        copy_wr_next  = 1'b0;
        copy_idx_next = copy_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        rd_idx        = idx_reg;
        s_ready       = 1'b0;
        key_clear     = 1'b0;
        slot_claim    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = !key_last || out_free;
                if (s_valid && s_ready && key_last) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                if (kstat.overflow) begin
                    m_valid_next           = 1'b1;
                    m_data_next.slot_index = '0;
                    m_data_next.status     = ST_TOO_LONG;
                    m_data_next.slots_used = sstat.count;
                    key_clear              = 1'b1;
                    state_next             = S_IDLE;
                end else begin
                    pos_next    = kstat.hash;
                    probes_next = '0;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE: begin
                idx_next = '0;
                if (!sstat.valid_at_pos) begin
                    state_next = (kstat.key_len == '0) ? S_CLAIM : S_COPY;
                end else begin
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                rd_idx   = '0;
                idx_next = '0;
                if (sstat.len_rd != kstat.key_len) begin
                    if (probes_reg == SLOT_W'(SLOTS - 1)) begin
                        m_valid_next           = 1'b1;
                        m_data_next.slot_index = '0;
                        m_data_next.status     = ST_FULL;
                        m_data_next.slots_used = sstat.count;
                        key_clear              = 1'b1;
                        state_next             = S_IDLE;
                    end else begin
                        pos_next    = pos_reg + kstat.step;
                        probes_next = probes_reg + SLOT_W'(1);
                        state_next  = S_PROBE;
                    end
                end else if (kstat.key_len == '0) begin
                    m_valid_next           = 1'b1;
                    m_data_next.slot_index = pos_reg;
                    m_data_next.status     = ST_FOUND;
                    m_data_next.slots_used = sstat.count;
                    key_clear              = 1'b1;
                    state_next             = S_IDLE;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                rd_idx   = idx_reg + IDX_W'(1);
                idx_next = idx_reg + IDX_W'(1);
                if (sstat.chr_rd != kstat.rd_data) begin
                    if (probes_reg == SLOT_W'(SLOTS - 1)) begin
                        m_valid_next           = 1'b1;
                        m_data_next.slot_index = '0;
                        m_data_next.status     = ST_FULL;
                        m_data_next.slots_used = sstat.count;
                        key_clear              = 1'b1;
                        state_next             = S_IDLE;
                    end else begin
                        pos_next    = pos_reg + kstat.step;
                        probes_next = probes_reg + SLOT_W'(1);
                        state_next  = S_PROBE;
                    end
                end else if (last_byte) begin
                    m_valid_next           = 1'b1;
                    m_data_next.slot_index = pos_reg;
                    m_data_next.status     = ST_FOUND;
                    m_data_next.slots_used = sstat.count;
                    key_clear              = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            S_COPY: begin
                rd_idx        = idx_reg;
                copy_wr_next  = 1'b1;
                copy_idx_next = idx_reg;
                idx_next      = idx_reg + IDX_W'(1);
                if (last_byte) begin
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM: begin
                slot_claim             = 1'b1;
                m_valid_next           = 1'b1;
                m_data_next.slot_index = pos_reg;
                m_data_next.status     = ST_CLAIMED;
                m_data_next.slots_used = sstat.count + CNT_W'(1);
                key_clear              = 1'b1;
                state_next             = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign kcmd.clear       = key_clear;
    assign kcmd.rd_idx      = rd_idx;
    assign scmd.pos         = pos_reg;
    assign scmd.claim       = slot_claim;
    assign scmd.claim_len   = kstat.key_len;
    assign scmd.chr_wr_en   = copy_wr_reg;
    assign scmd.chr_wr_addr = char_addr(pos_reg, copy_idx_reg);
    assign scmd.chr_wr_data = kstat.rd_data;
    assign scmd.chr_rd_addr = char_addr(pos_reg, rd_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            copy_wr_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            copy_wr_reg <= copy_wr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        probes_reg   <= probes_next;
        idx_reg      <= idx_next;
        copy_idx_reg <= copy_idx_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/double_hash_key_slot_table_core.sv =====
// Top level of the double-hashing key-to-slot table.
//
//   port group   dir  beat contents                         handshake
//   s_*          in   key_char, key_last                    s_valid / s_ready
//   m_*          out  slot_index, status, slots_used        m_valid / m_ready
//
// Key bytes without the last mark are taken while idle. A last byte starts a
// setup state (S_START), then per probe: an empty slot goes through S_PROBE,
// S_COPY (byte copy through the key buffer read port) and S_CLAIM, with no
// copy for an empty key; an occupied slot through S_PROBE and S_LEN, then, if
// the lengths match, S_CMP up to the first mismatch (slot memory read port).
// Reset (aresetn, synchronous) clears all claimed marks at once; no sweep.
// The next key's bytes are taken while a result waits in the output register;
// its last byte waits for that register to drain.
module double_hash_key_slot_table_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dhk_pkg::key_beat_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dhk_pkg::result_beat_t m_data
);
    import dhk_pkg::*;

    kacc_cmd_t  kcmd;
    kacc_stat_t kstat;
    slot_cmd_t  scmd;
    slot_stat_t sstat;
    logic       beat_acc;

    assign beat_acc = s_valid && s_ready;

    dhk_key_acc u_key_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_acc (beat_acc),
        .beat     (s_data),
        .cmd      (kcmd),
        .stat     (kstat)
    );

    dhk_slot_store u_slot_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (scmd),
        .stat    (sstat)
    );

    dhk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .key_last (s_data.key_last),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .kstat    (kstat),
        .kcmd     (kcmd),
        .sstat    (sstat),
        .scmd     (scmd)
    );

endmodule

// ===== sv/dhk_checker.sv =====
// Port-level checker for the slot table, bound to the top level.
`include "assert_macros.svh"

module dhk_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input dhk_pkg::key_beat_t    s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input dhk_pkg::result_beat_t m_data
);
    import dhk_pkg::*;

    `DHK_ASSERT_ALWAYS(a_rst_no_result, !aresetn |=> !m_valid, "result valid after reset")
    `DHK_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")
    `DHK_ASSERT(a_miss_slot_zero, m_valid && (m_data.status == ST_FULL || m_data.status == ST_TOO_LONG) |-> m_data.slot_index == '0, "slot index not zero on miss")
    `DHK_ASSERT(a_last_needs_room, s_valid && s_ready && s_data.key_last |-> !m_valid || m_ready, "last byte taken while result register full")

endmodule

bind double_hash_key_slot_table_core dhk_checker u_dhk_checker (.*);
